### hw/rtl/base64_stream_encoder_unit_assert.svh
// assertion macros shared by the rtl modules
// each expects clk and arst_n in scope
`ifndef BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH

// plain property, checked out of reset
`define B64_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define B64_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B64_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/b64_pkg.sv
`default_nettype none

package b64_pkg;

	// character codes
	localparam logic [7:0] CHAR_PAD     = 8'h3D;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// register map: word index taken from paddr[2]
	localparam logic REG_LINE_GROUPS = 1'b0;
	localparam logic [5:0] LINE_GROUPS_RESET = 6'd19;

	// one encoded group handed from front to back
	typedef struct packed {
		logic [23:0] grp;     // three bytes, missing ones zero
		logic [1:0]  pcnt;    // bytes in group minus one
		logic        nl;      // newline follows the group
	} job_t;

	// six-bit value to alphabet character
	function automatic logic [7:0] sym(input logic [5:0] v);
		logic [7:0] ve;
		logic [7:0] c;
		ve = {2'b00, v};
		case (v) inside
			[6'd0:6'd25]:  c = 8'h41 + ve;
			[6'd26:6'd51]: c = 8'h61 + ve - 8'd26;
			[6'd52:6'd61]: c = 8'h30 + ve - 8'd52;
			6'd62:         c = 8'h2B;
			default:       c = 8'h2F;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/b64_fifo.sv
`default_nettype none

module b64_fifo #(
	parameter int unsigned Depth = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire b64_pkg::job_t  push_data,
	input  wire                 pop,
	output b64_pkg::job_t       pop_data,
	output logic                full,
	output logic                empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	b64_pkg::job_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/b64_front.sv
`default_nettype none
`include "base64_stream_encoder_unit_assert.svh"

module b64_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire  [5:0]       line_groups,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [7:0]       s_tdata,   // [7:0] data_byte
	input  wire              s_tlast,   // is_final
	input  wire              q_full,
	output logic             push,
	output b64_pkg::job_t    push_data
);

	logic [15:0] pend_q;
	logic [1:0]  pend_cnt_q;
	logic [5:0]  gol_q;

	logic       acc;
	logic       group_done;
	logic [5:0] gol_next;
	logic       nl;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;

	// group closes on the third byte or on a final byte
	assign group_done = s_tlast || (pend_cnt_q >= 2'd2);
	assign push       = acc && group_done;
	assign gol_next   = gol_q + 6'd1;
	assign nl         = (line_groups != 6'd0) && (gol_next >= line_groups);

	// assemble the group, missing bytes as zero
	always_comb begin
		push_data.pcnt = (pend_cnt_q >= 2'd2) ? 2'd2 : pend_cnt_q;
		push_data.nl   = nl;
		case (push_data.pcnt)
			2'd0:    push_data.grp = {s_tdata, 16'h0000};
			2'd1:    push_data.grp = {pend_q[15:8], s_tdata, 8'h00};
			default: push_data.grp = {pend_q, s_tdata};
		endcase
	end

	// pending bytes and line position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			pend_cnt_q <= '0;
			gol_q      <= '0;
		end else if (acc) begin
			if (!group_done) begin
				if (pend_cnt_q == 2'd0) begin
					pend_q <= {s_tdata, 8'h00};
				end else begin
					pend_q <= {pend_q[15:8], s_tdata};
				end
				pend_cnt_q <= pend_cnt_q + 2'd1;
			end else begin
				pend_q     <= '0;
				pend_cnt_q <= '0;
				gol_q      <= (nl || s_tlast) ? 6'd0 : gol_next;
			end
		end
	end

	`B64_ASSERT(a_cnt_range, pend_cnt_q != 2'd3, "pending count out of range")
	`B64_ASSERT_NEXT(a_fin_clears, acc && s_tlast, {pend_cnt_q, gol_q} == 8'd0, "stale state")
	`B64_ASSERT_NEXT(a_line_bound, push && line_groups != 6'd0, gol_q < line_groups, "missed wrap")

endmodule

`default_nettype wire

### hw/rtl/b64_back.sv
`default_nettype none
`include "base64_stream_encoder_unit_assert.svh"

module b64_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_empty,
	input  wire b64_pkg::job_t  q_data,
	output logic                pop,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [7:0]          m_tdata,   // [7:0] out_char
	output logic                m_tlast    // run_last
);

	b64_pkg::job_t cur_q;
	logic          cur_valid_q;
	logic [2:0]    idx_q;
	logic          tvalid_q;
	logic [7:0]    tdata_q;
	logic          tlast_q;

	logic       out_free;
	logic       adv;
	logic [2:0] last_idx;
	logic       finish;
	logic [7:0] chr;

	assign out_free = !tvalid_q || m_tready;
	assign adv      = cur_valid_q && out_free;
	assign last_idx = cur_q.nl ? 3'd4 : 3'd3;
	assign finish   = adv && (idx_q == last_idx);
	assign pop      = !q_empty && (!cur_valid_q || finish);

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

	// character for the current slot of the group
	always_comb begin
		case (idx_q)
			3'd0:    chr = b64_pkg::sym(cur_q.grp[23:18]);
			3'd1:    chr = b64_pkg::sym(cur_q.grp[17:12]);
			3'd2:    chr = (cur_q.pcnt != 2'd0) ? b64_pkg::sym(cur_q.grp[11:6])
				: b64_pkg::CHAR_PAD;
			3'd3:    chr = (cur_q.pcnt == 2'd2) ? b64_pkg::sym(cur_q.grp[5:0])
				: b64_pkg::CHAR_PAD;
			default: chr = b64_pkg::CHAR_NEWLINE;
		endcase
	end

	// current group payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
	end

	// slot sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (finish) begin
			cur_valid_q <= 1'b0;
		end else if (adv) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (adv) begin
			tvalid_q <= 1'b1;
		end else if (m_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tdata_q <= chr;
			tlast_q <= finish;
		end
	end

	`B64_ASSERT_IMPL(a_idx_range, cur_valid_q, idx_q <= last_idx, "slot index past end of group")
	`B64_ASSERT_NEXT(a_drain, finish && !pop, !cur_valid_q, "group not retired")
	`B64_ASSERT_IMPL(a_pop_busy, pop && cur_valid_q, finish, "group replaced before done")

endmodule

`default_nettype wire

### hw/rtl/base64_stream_encoder_unit.sv
// Streaming base64 encoder, standard alphabet. Raw bytes enter on the s_ beat
// channel (tlast marks the final byte of a stream, which flushes a partial group
// with '=' padding and restarts line counting); characters leave on the m_
// channel, with tlast on the last character caused by an input byte. Every third
// byte (or a final byte) yields four characters, plus a newline when the line
// reaches line_groups groups (register at byte address 0, reset 19, 0 = no
// wrapping). The front end accepts one byte per cycle while the group queue has
// room; the back end sends one character per cycle while m_tready is high, so
// the output port sets the sustained rate. The byte that closes a group passes
// through the group queue, the current-group register and the output register
// before the first character of the group is valid on the output.
// QueueDepth sets the number of groups buffered between the two ends.
`default_nettype none

module base64_stream_encoder_unit #(
	parameter int unsigned QueueDepth = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	// input stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	input  wire         s_tlast,   // is_final
	// output stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_char
	output logic        m_tlast,   // run_last
	// register port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [5:0]    line_groups_q;
	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	b64_pkg::job_t push_data;
	b64_pkg::job_t pop_data;

	// register access
	assign pready = 1'b1;
	assign prdata = (paddr[2] == b64_pkg::REG_LINE_GROUPS) ? {26'd0, line_groups_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_groups_q <= b64_pkg::LINE_GROUPS_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == b64_pkg::REG_LINE_GROUPS) begin
			line_groups_q <= pwdata[5:0];
		end
	end

	b64_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_groups (line_groups_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	b64_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	b64_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### dv/base64_stream_encoder_checker.sv
`timescale 1ns / 1ps

module base64_stream_encoder_checker (
	input  wire         clk,
	input  wire         arst_n,
	// input stream
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	input  wire         s_tlast,   // is_final
	// output stream
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [7:0]  m_tdata,   // [7:0] out_char
	input  wire         m_tlast,   // run_last
	// register port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire  [31:0] prdata,
	input  wire         pready,
	output int          fail_count,
	output int          chars_owed
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// encoder state as the block should hold it
	logic [5:0]  lines_max;
	logic [15:0] held_bytes;
	logic [1:0]  held_count;
	logic [5:0]  line_fill;
	enc_char_t   chars_due[$];

	function automatic logic [7:0] b64_symbol(input logic [5:0] v);
		return ALPHABET[8*(63 - int'(v)) +: 8];
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch at %0t: %s got 0x%02h, expected 0x%02h", $time, what, got, want);
		fail_count++;
	endtask

	// one accepted byte: store it, or close the group and queue its characters
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [1:0]  cnt;
		logic [23:0] grp;
		logic [7:0]  chars [4];
		logic        wrap;
		cnt = (held_count > 2'd2) ? 2'd2 : held_count;
		if (cnt < 2'd2 && !fin) begin
			if (cnt == 2'd0)
				held_bytes = {b, 8'h00};
			else
				held_bytes[7:0] = b;
			held_count = cnt + 2'd1;
		end else begin
			// missing bytes of a short group count as zero
			case (cnt)
				2'd0:    grp = {b, 16'h0000};
				2'd1:    grp = {held_bytes[15:8], b, 8'h00};
				default: grp = {held_bytes, b};
			endcase
			chars[0] = b64_symbol(grp[23:18]);
			chars[1] = b64_symbol(grp[17:12]);
			chars[2] = (cnt != 2'd0) ? b64_symbol(grp[11:6]) : b64_pkg::CHAR_PAD;
			chars[3] = (cnt == 2'd2) ? b64_symbol(grp[5:0]) : b64_pkg::CHAR_PAD;
			// line wrap, also when the limit was lowered under the running count
			line_fill = line_fill + 6'd1;
			wrap = (lines_max != 6'd0) && (line_fill >= lines_max);
			if (wrap)
				line_fill = 6'd0;
			held_bytes = 16'h0000;
			held_count = 2'd0;
			if (fin)
				line_fill = 6'd0;
			for (int k = 0; k < 4; k++)
				chars_due.push_back(enc_char_t'({chars[k], !wrap && k == 3}));
			if (wrap)
				chars_due.push_back(enc_char_t'({b64_pkg::CHAR_NEWLINE, 1'b1}));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		enc_char_t want;
		if (!arst_n) begin
			lines_max = b64_pkg::LINE_GROUPS_RESET;
			held_bytes = 16'h0000;
			held_count = 2'd0;
			line_fill = 6'd0;
			chars_due.delete();
			chars_owed = 0;
			fail_count = 0;
		end else begin
			// register access
			if (psel && penable && pready && paddr[2] == b64_pkg::REG_LINE_GROUPS) begin
				if (pwrite)
					lines_max = pwdata[5:0];
				else if (prdata !== {26'h0, lines_max})
					report_mismatch("line_groups readback", prdata[7:0], {2'b00, lines_max});
			end
			// output beat against the oldest expected character
			if (m_tvalid && m_tready) begin
				if (chars_due.size() == 0) begin
					report_mismatch("unexpected character", m_tdata, 8'h00);
				end else begin
					want = chars_due.pop_front();
					if (m_tdata !== want.ch)
						report_mismatch("out_char", m_tdata, want.ch);
					if (m_tlast !== want.last)
						report_mismatch("run_last", {7'h0, m_tlast}, {7'h0, want.last});
				end
			end
			// input beat
			if (s_tvalid && s_tready)
				encode_byte(s_tdata, s_tlast);
			chars_owed = chars_due.size();
		end
	end

endmodule

### dv/tb_base64_stream_encoder_unit.sv
`timescale 1ns / 1ps

module tb_base64_stream_encoder_unit;

	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 120;
	localparam int NUM_PHASES = 5;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          chars_owed;

	// sender burst control and the long receiver hold-off
	int burst_left;
	bit gapless;
	bit hold_req;
	bit hold_done;

	// per random phase: line length, byte count, odds of a final byte (0 = never)
	int phase_lines [NUM_PHASES] = '{1, 0, 63, 2, -1};
	int phase_bytes [NUM_PHASES] = '{20, 200, 190, 30, 40};
	int phase_fin   [NUM_PHASES] = '{6, 0, 0, 5, 9};

	base64_stream_encoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	base64_stream_encoder_checker enc_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.chars_owed (chars_owed)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// receiver: stall modes of random length, plus one long hold-off on request
	initial begin
		int mode;
		int span;
		int tick;
		m_tready = 1'b0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(8, 48);
				repeat (span) begin
					@(negedge clk);
					tick++;
					case (mode)
						0:       m_tready <= 1'b1;
						1:       m_tready <= 1'($urandom_range(0, 1));
						2:       m_tready <= ($urandom_range(0, 3) == 0);
						default: m_tready <= (tick % 3 != 0);
					endcase
				end
			end
		end
	end

	// one byte beat; entered and left at a falling edge
	task automatic push_byte(input logic [7:0] b, input logic fin);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		if (!gapless) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				s_tvalid <= 1'b0;
				gap = $urandom_range(1, 6);
				repeat (gap) @(negedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
					: $urandom_range(0, 8);
			end
		end
	endtask

	// stop sending and let every expected character come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (chars_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// setup and access cycle, then the bus returns to idle
	task automatic reg_access(input logic wr, input logic [5:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {b64_pkg::REG_LINE_GROUPS, 2'b00};
		pwdata <= {26'($urandom_range(0, 32'h3FFFFFF)), v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_line_groups(input logic [5:0] v);
		reg_access(1'b1, v);
		reg_access(1'b0, 6'd0);
	endtask

	initial begin
		int lines;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'h0;
		burst_left = 0;
		gapless = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset value readback, then a newline after every group
		reg_access(1'b0, 6'd0);
		set_line_groups(6'd1);
		// one, two and three byte streams with extreme values
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFB, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(8'hBE, 1'b1);
		// full group not final, then a lone final byte
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'h83, 1'b0);
		wait_idle();

		// no wrapping: two groups on the line
		set_line_groups(6'd0);
		push_byte(8'h4D, 1'b0);
		push_byte(8'h61, 1'b0);
		push_byte(8'h6E, 1'b0);
		push_byte(8'h4D, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b0);
		wait_idle();

		// limit lowered under the running count: newline right after the group
		set_line_groups(6'd1);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b1);
		wait_idle();

		// random phases; long streams walk the line count past its wrap
		for (int p = 0; p < NUM_PHASES; p++) begin
			lines = (phase_lines[p] < 0) ? $urandom_range(3, 62) : phase_lines[p];
			set_line_groups(lines[5:0]);
			if (p == 1) begin
				// keep offering while the receiver holds off
				gapless = 1'b1;
				hold_req = 1'b1;
			end
			for (int i = 0; i < phase_bytes[p]; i++)
				push_byte(8'($urandom_range(0, 255)),
					phase_fin[p] != 0 && $urandom_range(1, phase_fin[p]) == 1);
			gapless = 1'b0;
			wait_idle();
		end

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/b64_pkg.sv
hw/rtl/b64_fifo.sv
hw/rtl/b64_front.sv
hw/rtl/b64_back.sv
hw/rtl/base64_stream_encoder_unit.sv
dv/base64_stream_encoder_checker.sv
dv/tb_base64_stream_encoder_unit.sv
